// ===== rtl/vq_codebook_yuv_decoder_unit_defines.svh =====
// Assertion macros for the checker file of the codebook decoder.
`ifndef VQ_CODEBOOK_YUV_DECODER_UNIT_DEFINES_SVH
`define VQ_CODEBOOK_YUV_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VQCB_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VQCB_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vqcb_pkg.sv =====
package vqcb_pkg;

  // Cell store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = 10;
  localparam int FRAC_BITS   = 40;

  // Result table codes
  typedef enum logic [1:0] {
    TBL_CELL2  = 2'd0,
    TBL_CELL4  = 2'd1,
    TBL_CELL8  = 2'd2,
    TBL_STATUS = 2'd3
  } tbl_t;

  // Chunk status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_SIZE  = 2'd2
  } status_t;

  // Work handed from the byte front end to the engine
  typedef enum logic [1:0] {
    JOB_CELL   = 2'd0,
    JOB_PAIR   = 2'd1,
    JOB_STATUS = 2'd2
  } job_kind_t;

  typedef enum logic [2:0] {
    ENG_CLEAR  = 3'd0,
    ENG_IDLE   = 3'd1,
    ENG_CELL   = 3'd2,
    ENG_PAIR   = 3'd3,
    ENG_STATUS = 3'd4
  } eng_state_t;

  typedef enum logic [1:0] {
    ROM_UB = 2'd0,
    ROM_VR = 2'd1,
    ROM_UG = 2'd2,
    ROM_VG = 2'd3
  } rom_sel_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        chunk_start;
    logic [15:0] chunk_flags;
    logic [16:0] chunk_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target_table;
    logic [13:0] word_index;
    logic [31:0] rgba_word;
    logic [1:0]  chunk_status;
    logic        run_last;
  } out_item_t;

  // cell jobs: bytes 0..3 luma, 4 u, 5 v; pair jobs: byte 0 first, byte 1 second
  typedef struct packed {
    job_kind_t       kind;
    logic            final_byte;
    status_t         status;
    logic [5:0][7:0] bytes;
    logic [10:0]     index;
  } job_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } eng_stat_t;

  typedef logic signed [15:0] rom_t [256];

  // Round a magnitude to 24 significant bits, nearest, ties to even
  function automatic logic [63:0] round24(input logic [63:0] mag, input logic sticky);
    int          len;
    int          sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    len = 0;
    for (int b = 0; b < 64; b++) begin
      if (mag[b]) len = b + 1;
    end
    if (len <= 24) return mag;
    sh   = len - 24;
    keep = mag >> sh;
    rem  = mag & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && (sticky || keep[0]))) keep = keep + 64'd1;
    return keep << sh;
  endfunction

  // num / 100000 in units of 2^-40, single-precision significand
  function automatic logic [63:0] dec_const(input logic [63:0] num);
    logic [63:0] s;
    s = num << FRAC_BITS;
    return round24(s / 64'd100000, (s % 64'd100000) != 64'd0);
  endfunction

  // c/2*64 + 0.5
  function automatic logic [63:0] coef(input logic [63:0] num);
    return round24((dec_const(num) << 5) + (64'd1 << (FRAC_BITS - 1)), 1'b0);
  endfunction

  function automatic longint rom_entry(input logic [63:0] t, input logic neg,
                                       input int x, input longint offs);
    logic [63:0] ax;
    logic [63:0] pm;
    logic [63:0] sm;
    logic        pneg;
    logic        sn;
    longint      p;
    longint      s;
    longint      ip;
    ax   = 64'((x < 0) ? -x : x);
    pneg = (x < 0) != neg;
    pm   = round24(t * ax, 1'b0);
    p    = pneg ? -$signed(pm) : $signed(pm);
    s    = p + offs * (longint'(1) <<< FRAC_BITS);
    sn   = s < 0;
    sm   = sn ? 64'(-s) : 64'(s);
    sm   = round24(sm, 1'b0);
    ip   = $signed(sm >> FRAC_BITS);
    return sn ? -ip : ip;
  endfunction

  // Chroma contribution tables, evaluated at elaboration
  function automatic rom_t build_rom(input rom_sel_t sel);
    rom_t        tab;
    logic [63:0] t;
    logic        neg;
    longint      offs;
    int          x;
    unique case (sel)
      ROM_UB: begin t = coef(64'd177200); neg = 1'b0; offs = 32; end
      ROM_VR: begin t = coef(64'd140200); neg = 1'b0; offs = 32; end
      ROM_UG: begin t = coef(64'd34414);  neg = 1'b1; offs = 0;  end
      default: begin t = coef(64'd71414); neg = 1'b1; offs = 32; end
    endcase
    for (int i = 0; i < 256; i++) begin
      x      = 2 * i - 255;
      tab[i] = 16'(rom_entry(t, neg, x, offs));
    end
    return tab;
  endfunction

endpackage

// ===== rtl/vq_codebook_yuv_decoder_unit.sv =====
// Codebook decoder for vector-quantized YUV video: takes the payload bytes of one
// codebook chunk on the in_ request channel and returns every 2x2, 4x4 and
// doubled 8x8 RGBA word it defines, plus a status request on the chunk's final
// byte, on the out_ channel. After reset the 1024-word cell store is cleared
// with in_stall held high. A byte that completes no cell is accepted even while
// earlier work is still being emitted. A byte that completes a 2x2 cell yields
// its converted words one per cycle while out_stall is low; the second byte of a
// 4x4 pair yields 40 words, one per cycle while out_stall is low and the single
// read port of the cell store has fetched the eight source words through rd_q_r
// and src_r. The status request follows the byte's words; the out_ register
// takes one word per cycle when out_stall is low.
module vq_codebook_yuv_decoder_unit #(
  parameter int MAX_CHUNK_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vqcb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vqcb_pkg::out_item_t out_data
);
  import vqcb_pkg::*;

  localparam int LEN_W = $clog2(MAX_CHUNK_BYTES + 1);

  logic [LEN_W-1:0] len_r, pos_r;
  logic [10:0]      first_r;
  status_t          err_r;
  logic [2:0]       slot_r;
  logic [7:0]       cell_r;
  logic [10:0]      pair_r;
  logic             parity_r;
  logic [4:0][7:0]  gath_r;
  job_t             job_r;
  logic             job_valid_r;

  logic [16:0]      len_clip;
  logic [8:0]       two_new, four_new;
  logic [10:0]      first_new;
  logic [11:0]      total_new;
  status_t          err_new;

  logic             start;
  logic [LEN_W-1:0] len_cur, pos_cur;
  logic [10:0]      first_cur;
  status_t          err_cur;
  logic [2:0]       slot_cur;
  logic [7:0]       cell_cur;
  logic [10:0]      pair_cur;
  logic             parity_cur;
  logic             active, in_cells2;
  logic             cell_job, pair_job, final_byte, makes_job;
  logic             accept;
  logic [LEN_W-1:0] pos_nxt;
  logic [2:0]       slot_nxt;
  logic [7:0]       cell_nxt;
  logic [10:0]      pair_nxt;
  logic             parity_nxt;
  job_t             job_nxt;
  eng_stat_t        eng_stat;

  // Chunk header decode
  always_comb begin
    len_clip = (in_data.chunk_bytes == 17'd0) ? 17'd1 : in_data.chunk_bytes;
    if (len_clip > 17'(MAX_CHUNK_BYTES)) len_clip = 17'(MAX_CHUNK_BYTES);
    two_new   = (in_data.chunk_flags[15:8] == 8'd0) ? 9'd256 : {1'b0, in_data.chunk_flags[15:8]};
    four_new  = (in_data.chunk_flags == 16'd0) ? 9'd256 : {1'b0, in_data.chunk_flags[7:0]};
    first_new = {two_new, 2'b00} + 11'({two_new, 1'b0});
    total_new = 12'(first_new) + 12'({four_new, 2'b00});
    if ({6'd0, first_new} > len_clip) err_new = ST_SHORT;
    else if (len_clip != {6'd0, first_new} && len_clip != {5'd0, total_new}) err_new = ST_SIZE;
    else err_new = ST_OK;
  end

  // Byte classification against the open chunk
  always_comb begin
    start      = in_data.chunk_start;
    len_cur    = start ? LEN_W'(len_clip) : len_r;
    pos_cur    = start ? '0 : pos_r;
    first_cur  = start ? first_new : first_r;
    err_cur    = start ? err_new : err_r;
    slot_cur   = start ? '0 : slot_r;
    cell_cur   = start ? '0 : cell_r;
    pair_cur   = start ? '0 : pair_r;
    parity_cur = start ? 1'b0 : parity_r;
    active     = pos_cur < len_cur;
    in_cells2  = pos_cur < LEN_W'(first_cur);
    cell_job   = active && in_cells2 && (err_cur != ST_SHORT) && (slot_cur == 3'd5);
    pair_job   = active && !in_cells2 && (err_cur == ST_OK) && parity_cur;
    final_byte = active && (pos_cur == len_cur - LEN_W'(1));
    makes_job  = cell_job || pair_job || final_byte;
  end

  // Position counters after this byte
  always_comb begin
    pos_nxt    = pos_cur;
    slot_nxt   = slot_cur;
    cell_nxt   = cell_cur;
    pair_nxt   = pair_cur;
    parity_nxt = parity_cur;
    if (active) begin
      pos_nxt = pos_cur + LEN_W'(1);
      if (in_cells2) begin
        slot_nxt = (slot_cur == 3'd5) ? 3'd0 : slot_cur + 3'd1;
        if (slot_cur == 3'd5) cell_nxt = cell_cur + 8'd1;
      end else if (err_cur == ST_OK) begin
        parity_nxt = ~parity_cur;
        if (parity_cur) pair_nxt = pair_cur + 11'd1;
      end
    end
  end

  // Job for the engine
  always_comb begin
    job_nxt            = '0;
    job_nxt.final_byte = final_byte;
    job_nxt.status     = err_cur;
    priority if (cell_job) begin
      job_nxt.kind  = JOB_CELL;
      job_nxt.bytes = {in_data.data_byte, gath_r};
      job_nxt.index = 11'(cell_cur);
    end else if (pair_job) begin
      job_nxt.kind  = JOB_PAIR;
      job_nxt.bytes = {32'd0, in_data.data_byte, gath_r[0]};
      job_nxt.index = pair_cur;
    end else begin
      job_nxt.kind  = JOB_STATUS;
    end
  end

  assign in_stall = eng_stat.clearing || (makes_job && job_valid_r && !eng_stat.take);
  assign accept   = in_valid && !in_stall;

  // Chunk tracking and job slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      first_r     <= '0;
      err_r       <= ST_OK;
      slot_r      <= '0;
      cell_r      <= '0;
      pair_r      <= '0;
      parity_r    <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        len_r    <= len_cur;
        first_r  <= first_cur;
        err_r    <= err_cur;
        pos_r    <= pos_nxt;
        slot_r   <= slot_nxt;
        cell_r   <= cell_nxt;
        pair_r   <= pair_nxt;
        parity_r <= parity_nxt;
      end
      if (accept && makes_job) job_valid_r <= 1'b1;
      else if (eng_stat.take) job_valid_r <= 1'b0;
    end
  end

  // Byte gathering and job payload
  always_ff @(posedge clk) begin
    if (accept && active) begin
      if (in_cells2 && slot_cur != 3'd5) gath_r[slot_cur] <= in_data.data_byte;
      if (!in_cells2 && !parity_cur) gath_r[0] <= in_data.data_byte;
    end
    if (accept && makes_job) job_r <= job_nxt;
  end

  vqcb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid_r),
    .job       (job_r),
    .stat      (eng_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/vqcb_engine.sv =====
module vqcb_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  vqcb_pkg::job_t      job,
  output vqcb_pkg::eng_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output vqcb_pkg::out_item_t out_data
);
  import vqcb_pkg::*;

  localparam rom_t UB_ROM = build_rom(ROM_UB);
  localparam rom_t VR_ROM = build_rom(ROM_VR);
  localparam rom_t UG_ROM = build_rom(ROM_UG);
  localparam rom_t VG_ROM = build_rom(ROM_VG);

  eng_state_t          state_r, state_nxt;
  job_t                job_r;
  logic [STORE_AW-1:0] clr_cnt_r;
  logic                j_r;
  logic                grp_r;
  logic [2:0]          k_r;
  logic [1:0]          rep_r;
  logic [3:0]          rd_cnt_r;
  logic [3:0]          cap_cnt_r;
  logic                rd_pend_r;
  logic [2:0]          rd_slot_r;
  logic [31:0]         src_r [8];
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [31:0]         store_mem [STORE_DEPTH];
  logic [31:0]         rd_q_r;
  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr;
  logic [31:0]         wr_data;
  logic [STORE_AW-1:0] rd_addr;
  logic                rd_go;

  logic                take;
  logic                can_load;
  logic                load;
  logic                step;
  logic                done;
  out_item_t           item;

  logic [7:0]          pix_y, pix_u, pix_v;
  logic signed [17:0]  yy, sum_r, sum_g, sum_b;
  logic signed [15:0]  ub_v, vr_v, ug_v, vg_v;
  logic [31:0]         pix_word;
  logic [2:0]          src_idx;
  logic                src_ready;
  logic [3:0]          b8_low;

  function automatic logic [7:0] clamp_chan(input logic signed [17:0] a);
    logic signed [11:0] q;
    q = 12'(a >>> 6);
    if (q < 0) return 8'd0;
    if (q > 12'sd255) return 8'd255;
    return q[7:0];
  endfunction

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    rd_q_r <= store_mem[rd_addr];
  end

  // YUV to RGBA for the current luma byte of a cell job
  always_comb begin
    pix_y    = job_r.bytes[k_r[1:0]];
    pix_u    = job_r.bytes[4];
    pix_v    = job_r.bytes[5];
    ub_v     = UB_ROM[pix_u];
    vr_v     = VR_ROM[pix_v];
    ug_v     = UG_ROM[pix_u];
    vg_v     = VG_ROM[pix_v];
    yy       = $signed({4'd0, pix_y, pix_y[7:2]});
    sum_r    = yy + {{2{vr_v[15]}}, vr_v};
    sum_g    = yy + {{2{ug_v[15]}}, ug_v} + {{2{vg_v[15]}}, vg_v};
    sum_b    = yy + {{2{ub_v[15]}}, ub_v};
    pix_word = {8'hFF, clamp_chan(sum_b), clamp_chan(sum_g), clamp_chan(sum_r)};
  end

  // Pair source selection: j picks the cell pair, k the word within it
  always_comb begin
    src_idx   = {j_r, grp_r ? k_r[2:1] : k_r[1:0]};
    src_ready = cap_cnt_r > {1'b0, src_idx};
    b8_low    = grp_r ? {1'b1, k_r} : {1'b0, k_r[1:0], rep_r == 2'd2};
    rd_addr   = {rd_cnt_r[1] ? job_r.bytes[1] : job_r.bytes[0], rd_cnt_r[2], rd_cnt_r[0]};
  end

  assign can_load = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_CLEAR: begin
        if (clr_cnt_r == STORE_AW'(STORE_DEPTH - 1)) state_nxt = ENG_IDLE;
      end
      ENG_IDLE: begin
        if (job_valid) begin
          unique case (job.kind)
            JOB_CELL: state_nxt = ENG_CELL;
            JOB_PAIR: state_nxt = ENG_PAIR;
            default:  state_nxt = ENG_STATUS;
          endcase
        end
      end
      ENG_CELL, ENG_PAIR: begin
        if (done) state_nxt = job_r.final_byte ? ENG_STATUS : ENG_IDLE;
      end
      ENG_STATUS: begin
        if (done) state_nxt = ENG_IDLE;
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    take    = 1'b0;
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = 32'd0;
    rd_go   = 1'b0;
    load    = 1'b0;
    step    = 1'b0;
    done    = 1'b0;
    item    = '0;
    unique case (state_r)
      ENG_CLEAR: begin
        wr_en = 1'b1;
      end
      ENG_IDLE: begin
        take = job_valid;
      end
      ENG_CELL: begin
        if (can_load) begin
          load              = 1'b1;
          step              = 1'b1;
          done              = k_r[1:0] == 2'd3;
          wr_en             = 1'b1;
          wr_addr           = {job_r.index[7:0], k_r[1:0]};
          wr_data           = pix_word;
          item.target_table = TBL_CELL2;
          item.word_index   = 14'({job_r.index[7:0], k_r[1:0]});
          item.rgba_word    = pix_word;
          item.chunk_status = job_r.status;
          item.run_last     = done && !job_r.final_byte;
        end
      end
      ENG_PAIR: begin
        rd_go = !rd_cnt_r[3];
        if (can_load && src_ready) begin
          load              = 1'b1;
          step              = 1'b1;
          done              = j_r && grp_r && (k_r == 3'd7);
          item.rgba_word    = src_r[src_idx];
          item.chunk_status = job_r.status;
          item.run_last     = done && !job_r.final_byte;
          if (!grp_r && rep_r == 2'd0) begin
            item.target_table = TBL_CELL4;
            item.word_index   = {job_r.index, j_r, k_r[1:0]};
          end else begin
            item.target_table = TBL_CELL8;
            item.word_index   = {job_r.index[8:0], j_r, b8_low};
          end
        end
      end
      ENG_STATUS: begin
        if (can_load) begin
          load              = 1'b1;
          done              = 1'b1;
          item.target_table = TBL_STATUS;
          item.chunk_status = job_r.status;
          item.run_last     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_CLEAR;
      clr_cnt_r   <= '0;
      j_r         <= 1'b0;
      grp_r       <= 1'b0;
      k_r         <= '0;
      rep_r       <= '0;
      rd_cnt_r    <= '0;
      cap_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      rd_slot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_go;
      rd_slot_r <= rd_cnt_r[2:0];
      if (state_r == ENG_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (take) begin
        j_r       <= 1'b0;
        grp_r     <= 1'b0;
        k_r       <= '0;
        rep_r     <= '0;
        rd_cnt_r  <= '0;
        cap_cnt_r <= '0;
      end else begin
        if (rd_go) rd_cnt_r <= rd_cnt_r + 1'b1;
        if (rd_pend_r) cap_cnt_r <= cap_cnt_r + 1'b1;
        if (step) begin
          priority if (state_r == ENG_CELL) begin
            k_r <= k_r + 1'b1;
          end else if (!grp_r) begin
            if (rep_r == 2'd2) begin
              rep_r <= '0;
              if (k_r[1:0] == 2'd3) begin
                grp_r <= 1'b1;
                k_r   <= '0;
              end else begin
                k_r <= k_r + 1'b1;
              end
            end else begin
              rep_r <= rep_r + 1'b1;
            end
          end else begin
            if (k_r == 3'd7) begin
              grp_r <= 1'b0;
              k_r   <= '0;
              j_r   <= ~j_r;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
      end
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) job_r <= job;
    if (rd_pend_r) src_r[rd_slot_r] <= rd_q_r;
    if (load) out_data_r <= item;
  end

  assign stat.take     = take;
  assign stat.clearing = state_r == ENG_CLEAR;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// ===== rtl/vqcb_checker.sv =====
`include "vq_codebook_yuv_decoder_unit_defines.svh"

module vqcb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input vqcb_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input vqcb_pkg::out_item_t out_data
);
  import vqcb_pkg::*;

  // A stalled result holds
  `VQCB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // Store clearing runs right after reset
  `VQCB_ASSERT_IMPLY(a_clear_stall, clk, rst_n, $rose(rst_n), in_stall, "input taken during store clear")

  // A too-short chunk writes no 2x2 words
  `VQCB_ASSERT_IMPLY(a_cell2_status, clk, rst_n, out_valid && (out_data.target_table == TBL_CELL2), out_data.chunk_status != ST_SHORT, "2x2 word from too-short chunk")

  // 4x4 and 8x8 words only come from well-sized chunks
  `VQCB_ASSERT_IMPLY(a_pair_status, clk, rst_n, out_valid && ((out_data.target_table == TBL_CELL4) || (out_data.target_table == TBL_CELL8)), out_data.chunk_status == ST_OK, "pair word from bad chunk")

  // The status result always closes its byte's run
  `VQCB_ASSERT_IMPLY(a_status_last, clk, rst_n, out_valid && (out_data.target_table == TBL_STATUS), out_data.run_last, "status result not last")

endmodule

bind vq_codebook_yuv_decoder_unit vqcb_checker u_vqcb_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vqcb_pkg::*;

  localparam int          MAX_LEN      = 65536;
  localparam int          FIX_FRAC     = 40;
  localparam longint      COEF_UB      = 177200;
  localparam longint      COEF_VR      = 140200;
  localparam longint      COEF_UG      = 34414;
  localparam longint      COEF_VG      = 71414;
  localparam int          PREDICTED    = -1;
  localparam int          RANDOM_ITEMS = 120;
  localparam int          HOLD_AT      = 150;
  localparam int          HOLD_CYCLES  = 500;
  localparam int          DRAIN_CYCLES = 100;
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;

  // One directed row: the request and, where it is obvious, its status result
  typedef struct {
    in_item_t req;
    int       n_typed;
    status_t  typed_st;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Mirror of the decoder state
  logic [31:0] cell_words [1024];
  int unsigned pos_q;
  int unsigned len_q;
  int unsigned n_cell2;
  int unsigned n_cell4;
  logic [47:0] gathered;
  status_t     chunk_st;
  int          ub_tab [256];
  int          vr_tab [256];
  int          ug_tab [256];
  int          vg_tab [256];

  out_item_t step_q[$];
  out_item_t due_words[$];
  dir_row_t  stim_rows[$];

  int        errs = 0;
  bit        in_calm = 1'b0;
  bit        out_calm = 1'b0;
  int        got_cnt = 0;
  int        rx_wait = 0;
  bit        hold_on = 1'b0;
  out_item_t want_w;

  vq_codebook_yuv_decoder_unit #(
    .MAX_CHUNK_BYTES(MAX_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Round a magnitude to a 24-bit significand, nearest even
  function automatic logic [63:0] round_sig24(input logic [63:0] mag, input bit sticky);
    int          msb;
    int          sh;
    logic [63:0] kept;
    logic [63:0] rest;
    logic [63:0] halfway;
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) msb = i + 1;
    end
    if (msb <= 24) return mag;
    sh      = msb - 24;
    kept    = mag >> sh;
    rest    = mag - (kept << sh);
    halfway = 64'd1 << (sh - 1);
    if (rest > halfway || (rest == halfway && (sticky || kept[0]))) kept = kept + 64'd1;
    return kept << sh;
  endfunction

  // c/2*64 + 0.5 for c = num / 100000, in units of 2^-40
  function automatic logic [63:0] scale_coef(input longint num);
    logic [63:0] scaled;
    logic [63:0] c;
    scaled = 64'(num) << FIX_FRAC;
    c      = round_sig24(scaled / 64'd100000, (scaled % 64'd100000) != 64'd0);
    return round_sig24((c << 5) + (64'd1 << (FIX_FRAC - 1)), 1'b0);
  endfunction

  // One chroma table entry: trunc(+-t*x + offs)
  function automatic int chroma_entry(input logic [63:0] t, input bit neg, input int x,
                                      input longint offs);
    logic [63:0] ax;
    logic [63:0] pm;
    logic [63:0] sm;
    bit          sn;
    longint      s;
    longint      ip;
    ax = 64'((x < 0) ? -x : x);
    pm = round_sig24(t * ax, 1'b0);
    s  = (((x < 0) != neg) ? -longint'(pm) : longint'(pm)) + (offs <<< FIX_FRAC);
    sn = s < 0;
    sm = round_sig24(sn ? 64'(-s) : 64'(s), 1'b0);
    ip = longint'(sm >> FIX_FRAC);
    return int'(sn ? -ip : ip);
  endfunction

  function automatic logic [7:0] clamp_chan(input int acc);
    int q;
    q = acc >>> 6;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return 8'(q);
  endfunction

  function automatic logic [31:0] yuv_to_rgba(input logic [7:0] y, input logic [7:0] u,
                                              input logic [7:0] v);
    int luma;
    luma = (int'(y) << 6) | (int'(y) >> 2);
    return {8'hFF, clamp_chan(luma + ub_tab[u]), clamp_chan(luma + ug_tab[u] + vg_tab[v]),
            clamp_chan(luma + vr_tab[v])};
  endfunction

  function automatic void push_word(input tbl_t tb, input int unsigned idx,
                                    input logic [31:0] w);
    out_item_t r;
    r.target_table = tb;
    r.word_index   = 14'(idx);
    r.rgba_word    = w;
    r.chunk_status = chunk_st;
    r.run_last     = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  // Expected words for one accepted byte, left in step_q
  function automatic void decode_byte(input in_item_t it);
    int unsigned len;
    int unsigned two;
    int unsigned four;
    int unsigned p;
    int unsigned first;
    int unsigned slot;
    int unsigned cell_no;
    int unsigned off;
    int unsigned a;
    int unsigned pair;
    int unsigned ia;
    int unsigned ib;
    int unsigned b4;
    int unsigned b8;
    logic [31:0] w;
    logic [31:0] src [4];
    step_q.delete();
    // chunk header sampled on the start byte
    if (it.chunk_start) begin
      len = it.chunk_bytes;
      if (len == 0) len = 1;
      if (len > MAX_LEN) len = MAX_LEN;
      if (it.chunk_flags == 16'd0) begin
        two  = 256;
        four = 256;
      end else begin
        two = it.chunk_flags[15:8];
        if (two == 0) two = 256;
        four = it.chunk_flags[7:0];
      end
      n_cell2  = two;
      n_cell4  = four * 2;
      len_q    = len;
      pos_q    = 0;
      gathered = '0;
      if (len < 6 * n_cell2) chunk_st = ST_SHORT;
      else if (len != 6 * n_cell2 && len != 6 * n_cell2 + 2 * n_cell4) chunk_st = ST_SIZE;
      else chunk_st = ST_OK;
    end
    if (pos_q >= len_q) return;
    p     = pos_q;
    first = 6 * n_cell2;
    if (p < first) begin
      // 2x2 phase: six bytes per cell
      if (chunk_st != ST_SHORT) begin
        slot = p % 6;
        gathered[8*slot +: 8] = it.data_byte;
        if (slot == 5) begin
          cell_no = p / 6;
          for (int k = 0; k < 4; k++) begin
            w = yuv_to_rgba(gathered[8*k +: 8], gathered[39:32], it.data_byte);
            cell_words[(cell_no * 4 + k) % 1024] = w;
            push_word(TBL_CELL2, (cell_no * 4 + k) % 1024, w);
          end
        end
      end
    end else if (chunk_st == ST_OK) begin
      // 4x4 phase: a byte pair picks two cells
      off = p - first;
      if (off % 2 == 0) begin
        gathered = {40'd0, it.data_byte};
      end else begin
        a    = gathered[7:0];
        pair = off / 2;
        for (int j = 0; j < 2; j++) begin
          ia     = a * 4 + 2 * j;
          ib     = int'(it.data_byte) * 4 + 2 * j;
          src[0] = cell_words[ia % 1024];
          src[1] = cell_words[(ia + 1) % 1024];
          src[2] = cell_words[ib % 1024];
          src[3] = cell_words[(ib + 1) % 1024];
          b4     = pair * 8 + j * 4;
          b8     = pair * 32 + j * 16;
          for (int k = 0; k < 4; k++) begin
            push_word(TBL_CELL4, b4 + k, src[k]);
            push_word(TBL_CELL8, b8 + 2 * k, src[k]);
            push_word(TBL_CELL8, b8 + 2 * k + 1, src[k]);
          end
          for (int k = 0; k < 8; k++) push_word(TBL_CELL8, b8 + 8 + k, src[k / 2]);
        end
      end
    end
    if (p == len_q - 1) push_word(TBL_STATUS, 0, 32'd0);
    pos_q = p + 1;
    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
  endfunction

  function automatic in_item_t mk_req(input int d, input bit s, input int f, input int n);
    in_item_t r;
    r.data_byte   = 8'(d);
    r.chunk_start = s;
    r.chunk_flags = 16'(f);
    r.chunk_bytes = 17'(n);
    return r;
  endfunction

  function automatic void add_row(input int d, input bit s, input int f, input int n,
                                  input int n_typed, input status_t st);
    dir_row_t r;
    r.req      = mk_req(d, s, f, n);
    r.n_typed  = n_typed;
    r.typed_st = st;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic void cmp_field(input string nm, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", nm, want, got);
      errs++;
    end
  endfunction

  // Offer one request, wait for the handshake, then predict its words
  task automatic send_req(input in_item_t req, input int n_typed, input status_t typed_st,
                          output bit live);
    int        gap;
    out_item_t typed;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 24) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    live = req.chunk_start || (pos_q < len_q);
    decode_byte(req);
    if (n_typed == PREDICTED) begin
      foreach (step_q[i]) due_words.insert(due_words.size(), step_q[i]);
    end else if (n_typed == 1) begin
      typed = '{TBL_STATUS, 14'd0, 32'd0, typed_st, 1'b1};
      due_words.insert(due_words.size(), typed);
    end
  endtask

  // Long receiver hold-off once enough results have come back
  initial begin
    wait (got_cnt >= HOLD_AT);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Result side: check, then stall per result and during the hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        got_cnt++;
        if (due_words.size() == 0) begin
          $error("unexpected result: table %0d index %0d word %0h",
                 out_data.target_table, out_data.word_index, out_data.rgba_word);
          errs++;
        end else begin
          want_w = due_words.pop_front();
          cmp_field("target_table", want_w.target_table, out_data.target_table);
          cmp_field("word_index", want_w.word_index, out_data.word_index);
          cmp_field("rgba_word", want_w.rgba_word, out_data.rgba_word);
          cmp_field("chunk_status", want_w.chunk_status, out_data.chunk_status);
          cmp_field("run_last", want_w.run_last, out_data.run_last);
        end
        rx_wait = out_calm ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 59) == 0) out_calm = !out_calm;
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int          kind;
    int          c2;
    int          lo;
    int          full;
    int          len;
    int          cut;
    int          flg;
    int          two;
    int          d;
    int          x;
    int          live_cnt;
    bit          live;
    logic [63:0] k_ub;
    logic [63:0] k_vr;
    logic [63:0] k_ug;
    logic [63:0] k_vg;

    // chroma tables and predictor reset state
    k_ub = scale_coef(COEF_UB);
    k_vr = scale_coef(COEF_VR);
    k_ug = scale_coef(COEF_UG);
    k_vg = scale_coef(COEF_VG);
    for (int i = 0; i < 256; i++) begin
      x         = 2 * i - 255;
      ub_tab[i] = chroma_entry(k_ub, 1'b0, x, 32);
      vr_tab[i] = chroma_entry(k_vr, 1'b0, x, 32);
      ug_tab[i] = chroma_entry(k_ug, 1'b1, x, 0);
      vg_tab[i] = chroma_entry(k_vg, 1'b1, x, 32);
    end
    foreach (cell_words[i]) cell_words[i] = '0;
    pos_q    = 0;
    len_q    = 0;
    n_cell2  = 0;
    n_cell4  = 0;
    gathered = '0;
    chunk_st = ST_OK;
    live_cnt = 0;

    // directed table
    // byte before any chunk is ignored
    add_row(8'h5A, 1'b0, 16'h1234, 17'h00010, 0, ST_OK);
    // zero length counts as one; one cell needs six bytes
    add_row(8'hFF, 1'b1, 16'h0100, 17'h00000, 1, ST_SHORT);
    // zero flags: 256 cells, far too short
    add_row(8'h00, 1'b1, 16'h0000, 17'h00001, 1, ST_SHORT);
    // byte past the chunk end is ignored
    add_row(8'hFF, 1'b0, 16'hFFFF, 17'h1FFFF, 0, ST_OK);
    // oversize length, wrong total: the cell is still written, then abandoned
    add_row(8'h00, 1'b1, 16'hFFFF, 17'h1FFFF, PREDICTED, ST_OK);
    add_row(8'hFF, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h80, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h7F, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h00, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'hFF, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    // restart: one cell plus two 4x4 pairs
    add_row(8'hFF, 1'b1, 16'h0101, 17'h0000A, PREDICTED, ST_OK);
    add_row(8'h00, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h7F, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h80, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'hFF, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h00, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h00, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h00, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'hFF, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h00, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    // length covers the 2x2 phase only
    add_row(8'h10, 1'b1, 16'h0103, 17'h00006, PREDICTED, ST_OK);
    add_row(8'hEB, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h80, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h40, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'hC0, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);
    add_row(8'h20, 1'b0, 16'h0000, 17'h00000, PREDICTED, ST_OK);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) send_req(stim_rows[i].req, stim_rows[i].n_typed,
                                    stim_rows[i].typed_st, live);

    // random chunks, mostly well formed
    while (live_cnt < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      c2   = $urandom_range(1, 6);
      lo   = $urandom_range(0, 4);
      full = 6 * c2 + 4 * lo;
      flg  = (c2 << 8) | lo;
      len  = full;
      cut  = full;
      case (kind)
        6: begin
          len = 6 * c2;
          cut = len;
        end
        7: begin
          len = (lo > 0 && $urandom_range(0, 1) == 1) ? full - 1 : full + $urandom_range(1, 3);
          cut = len;
        end
        8: begin
          flg = $urandom_range(0, 16'hFFFF);
          two = (flg >> 8) & 255;
          if (two == 0) two = 256;
          len = $urandom_range(1, (6 * two - 1 < 14) ? 6 * two - 1 : 14);
          cut = len;
        end
        9: cut = $urandom_range(1, full - 1);
        default: ;
      endcase
      for (int b = 0; b < cut; b++) begin
        if (kind != 8 && b >= 6 * c2) begin
          d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, c2 - 1);
        end else begin
          d = $urandom_range(0, 255);
        end
        if (b == 0) begin
          send_req(mk_req(d, 1'b1, flg, len), PREDICTED, ST_OK, live);
        end else begin
          send_req(mk_req(d, 1'b0, $urandom_range(0, 16'hFFFF), $urandom_range(0, 17'h1FFFF)),
                   PREDICTED, ST_OK, live);
        end
        if (live) live_cnt++;
      end
      // stray bytes after a closed chunk
      if (kind != 9 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          send_req(mk_req($urandom_range(0, 255), 1'b0, $urandom_range(0, 16'hFFFF),
                          $urandom_range(0, 17'h1FFFF)), PREDICTED, ST_OK, live);
        end
      end
    end
    in_valid <= 1'b0;

    // drain
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
